>>> rtl/ats_pkg.sv
`timescale 1ns / 1ps

package ats_pkg;

   // Table geometry and arithmetic widths.
   localparam int MAX_CITIES      = 256;
   localparam int CITY_BITS       = $clog2(MAX_CITIES);
   localparam int COUNT_BITS      = CITY_BITS + 1;
   localparam int WEIGHT_BITS     = 32;
   localparam int RANDOM_BITS     = 16;
   localparam int SUM_BITS        = WEIGHT_BITS + CITY_BITS;
   localparam int THR_BITS        = SUM_BITS + 1;
   localparam int TABLE_DEPTH     = MAX_CITIES * MAX_CITIES;
   localparam int TABLE_ADDR_BITS = 2 * CITY_BITS;

   localparam logic [COUNT_BITS-1:0] CITY_COUNT_RESET = COUNT_BITS'(MAX_CITIES);
   localparam logic [COUNT_BITS-1:0] CITY_COUNT_MIN   = COUNT_BITS'(2);

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_STEP  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [CITY_BITS-1:0] city;
      logic                 no_city;
      logic                 last;
   } result_type;

   // Status handed from the tour sequencer to the top level.
   typedef struct packed {
      logic       idle;
      logic       done;
      result_type result;
   } ctrl_status_type;

   // Clamps the configured count into the range the hardware supports.
   function automatic logic [COUNT_BITS-1:0] cities_in_use(input logic [COUNT_BITS-1:0] cnt);
      logic [COUNT_BITS-1:0] n;
      n = cnt;
      if (n < CITY_COUNT_MIN) n = CITY_COUNT_MIN;
      if (n > CITY_COUNT_RESET) n = CITY_COUNT_RESET;
      return n;
   endfunction

endpackage

>>> rtl/ats_ram.sv
`timescale 1ns / 1ps

module ats_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ats_ctrl.sv
`timescale 1ns / 1ps

module ats_ctrl import ats_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_accept,
   input  op_type                     req_op,
   input  logic [CITY_BITS-1:0]       req_from,
   input  logic [RANDOM_BITS-1:0]     req_rand,
   input  logic [COUNT_BITS-1:0]      city_count,
   input  logic                       result_ready,
   input  logic [WEIGHT_BITS-1:0]     ram_rd_data,
   output logic [TABLE_ADDR_BITS-1:0] scan_addr,
   output ctrl_status_type            status
);

   typedef enum logic [2:0] {
      IDLE,
      SUM,
      MUL,
      SEL,
      DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [COUNT_BITS-1:0]     idx_ff, idx_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [CITY_BITS-1:0]      rd_city_ff, rd_city_in;
   logic                      rd_unvis_ff, rd_unvis_in;
   logic [SUM_BITS-1:0]       sum_ff, sum_in;
   logic [SUM_BITS-1:0]       run_ff, run_in;
   logic [THR_BITS-1:0]       thr_ff, thr_in;
   logic [1:0]                unvis_ff, unvis_in;
   logic [CITY_BITS-1:0]      first_ff, first_in;
   logic [CITY_BITS-1:0]      pick_ff, pick_in;
   logic                      found_ff, found_in;
   logic [RANDOM_BITS-1:0]    rand_ff, rand_in;
   logic [MAX_CITIES-1:0]     visited_ff, visited_in;
   logic [CITY_BITS-1:0]      current_ff, current_in;

   logic                             issue;
   logic                             take;
   logic [SUM_BITS-1:0]              weight_ext;
   logic [SUM_BITS-1:0]              run_sum;
   logic [SUM_BITS+RANDOM_BITS-1:0]  product;
   logic [CITY_BITS-1:0]             start_city;
   logic [CITY_BITS-1:0]             chosen;

   assign issue = (state_ff == SUM || (state_ff == SEL && !found_ff)) && (idx_ff < city_count);
   assign take = rd_valid_ff && rd_unvis_ff;
   assign weight_ext = SUM_BITS'(ram_rd_data);
   assign run_sum = run_ff + weight_ext;
   assign product = (SUM_BITS+RANDOM_BITS)'(sum_ff) * (SUM_BITS+RANDOM_BITS)'(rand_ff);
   assign start_city = ({1'b0, req_from} >= city_count) ?
                       CITY_BITS'(city_count - COUNT_BITS'(1)) : req_from;
   assign chosen = found_ff ? pick_ff : first_ff;
   assign scan_addr = {current_ff, idx_ff[CITY_BITS-1:0]};

   always_comb begin
      state_in    = state_ff;
      idx_in      = issue ? idx_ff + COUNT_BITS'(1) : idx_ff;
      rd_valid_in = issue;
      rd_city_in  = idx_ff[CITY_BITS-1:0];
      rd_unvis_in = !visited_ff[idx_ff[CITY_BITS-1:0]];
      sum_in      = sum_ff;
      run_in      = run_ff;
      thr_in      = thr_ff;
      unvis_in    = unvis_ff;
      first_in    = first_ff;
      pick_in     = pick_ff;
      found_in    = found_ff;
      rand_in     = rand_ff;
      visited_in  = visited_ff;
      current_in  = current_ff;

      case (state_ff)
         IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_START: begin
                     visited_in             = '0;
                     visited_in[start_city] = 1'b1;
                     current_in             = start_city;
                  end
                  OP_STEP: begin
                     rand_in  = req_rand;
                     idx_in   = '0;
                     sum_in   = '0;
                     unvis_in = '0;
                     state_in = SUM;
                  end
                  default: begin
                  end
               endcase
            end
         end
         SUM: begin
            if (take) begin
               sum_in = sum_ff + weight_ext;
               if (unvis_ff == 2'd0) first_in = rd_city_ff;
               if (unvis_ff != 2'd2) unvis_in = unvis_ff + 2'd1;
            end
            if (!issue && !rd_valid_ff) state_in = MUL;
         end
         MUL: begin
            // Threshold is floor(sum * random / 2^RANDOM_BITS) + 1.
            thr_in   = THR_BITS'(product[SUM_BITS+RANDOM_BITS-1:RANDOM_BITS]) + THR_BITS'(1);
            idx_in   = '0;
            run_in   = '0;
            found_in = 1'b0;
            state_in = (unvis_ff == 2'd0) ? DONE : SEL;
         end
         SEL: begin
            if (take && !found_ff) begin
               run_in = run_sum;
               if ({1'b0, run_sum} >= thr_ff) begin
                  found_in = 1'b1;
                  pick_in  = rd_city_ff;
               end
            end
            if (found_ff || (!issue && !rd_valid_ff)) state_in = DONE;
         end
         DONE: begin
            if (result_ready) begin
               if (unvis_ff != 2'd0) begin
                  visited_in[chosen] = 1'b1;
                  current_in         = chosen;
               end
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_city_ff  <= rd_city_in;
      rd_unvis_ff <= rd_unvis_in;
      sum_ff      <= sum_in;
      run_ff      <= run_in;
      thr_ff      <= thr_in;
      first_ff    <= first_in;
      pick_ff     <= pick_in;
      rand_ff     <= rand_in;
      if (reset) begin
         state_ff    <= IDLE;
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
         unvis_ff    <= '0;
         found_ff    <= 1'b0;
         visited_ff  <= '0;
         current_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         rd_valid_ff <= rd_valid_in;
         unvis_ff    <= unvis_in;
         found_ff    <= found_in;
         visited_ff  <= visited_in;
         current_ff  <= current_in;
      end
   end

   always_comb begin
      status.idle           = (state_ff == IDLE);
      status.done           = (state_ff == DONE);
      status.result.no_city = (unvis_ff == 2'd0);
      status.result.last    = (unvis_ff == 2'd1);
      status.result.city    = (unvis_ff == 2'd0) ? '0 : chosen;
   end

endmodule

>>> rtl/ant_tour_roulette_select.sv
`timescale 1ns / 1ps

// Roulette-wheel choice of the next city for one ant's tour. A load word (tuser 0) writes one
// 32-bit desirability weight into a 256 x 256 table held in a single-port synchronous RAM, a
// start word (tuser 1) clears the visited map and makes the start city current, and a step
// word (tuser 2) picks the next unvisited city with probability in proportion to its weight
// and returns one result word; tuser 3 is ignored. Load and start words leave the block idle,
// ready for the next word. A step reads the current city's row through the RAM port twice,
// one city per cycle: once to sum the weights of the unvisited cities, once to walk the
// running sum up to the threshold; the walk stops early once the sum reaches it. A finished
// result sits in an output register, so loads and starts are taken while it waits; a further
// step finishes only once the earlier result has been taken. The city count register is to be
// written only while the block is idle; the block itself does not enforce this. The table has
// no reset, and a step must only read weights that were loaded.

module ant_tour_roulette_select import ats_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Input words.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,  // from_city, to_city, weight, random_fraction
   input  logic [1:0]            req_tuser,  // operation
   // Result words.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // chosen_city
   output logic                  rsp_tuser,  // status
   output logic                  rsp_tlast,  // tour_complete
   // City count register.
   input  logic                  csr_wr_en,
   input  logic [COUNT_BITS-1:0] csr_wr_data
);

   logic [COUNT_BITS-1:0]      city_count_ff;
   logic [COUNT_BITS-1:0]      cities;
   logic                       req_accept;
   op_type                     req_op;
   logic [CITY_BITS-1:0]       req_from;
   logic [CITY_BITS-1:0]       req_to;
   logic [WEIGHT_BITS-1:0]     req_weight;
   logic [RANDOM_BITS-1:0]     req_rand;
   logic                       table_wr_en;
   logic [TABLE_ADDR_BITS-1:0] table_addr;
   logic [TABLE_ADDR_BITS-1:0] scan_addr;
   logic [WEIGHT_BITS-1:0]     table_rd_data;
   ctrl_status_type            ctrl_status;
   logic                       rsp_valid_ff;
   result_type                 rsp_result_ff;
   logic                       rsp_load;

   // Unpack the input word.
   assign req_op     = op_type'(req_tuser);
   assign req_from   = req_tdata[7:0];
   assign req_to     = req_tdata[15:8];
   assign req_weight = req_tdata[47:16];
   assign req_rand   = req_tdata[63:48];

   assign req_tready = ctrl_status.idle;
   assign req_accept = req_tvalid && req_tready;

   assign cities = cities_in_use(city_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CITY_COUNT_RESET;
      end else if (csr_wr_en) begin
         city_count_ff <= csr_wr_data;
      end
   end

   // The RAM port is shared: a load writes at (row, column), otherwise the scan reads.
   assign table_wr_en = req_accept && (req_op == OP_LOAD);
   assign table_addr  = table_wr_en ? {req_from, req_to} : scan_addr;

   ats_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_wr_en),
      .addr    (table_addr),
      .wr_data (req_weight),
      .rd_data (table_rd_data)
   );

   ats_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req_op       (req_op),
      .req_from     (req_from),
      .req_rand     (req_rand),
      .city_count   (cities),
      .result_ready (rsp_load),
      .ram_rd_data  (table_rd_data),
      .scan_addr    (scan_addr),
      .status       (ctrl_status)
   );

   // Output register: refilled when empty or when its word is being taken.
   assign rsp_load = ctrl_status.done && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_result_ff <= ctrl_status.result;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_result_ff.city;
   assign rsp_tuser  = rsp_result_ff.no_city;
   assign rsp_tlast  = rsp_result_ff.last;

endmodule

>>> rtl/ats_check.sv
`timescale 1ns / 1ps

module ats_check import ats_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // A step with no unvisited city reports city zero and no tour end.
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0 && !rsp_tlast)
      else $error("error result carries a city or tour end");

   // A step word keeps the block busy for at least the next cycle.
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_STEP |=> !req_tready)
      else $error("block ready right after a step word");

   // A new result only appears out of a step in progress.
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while the block was idle");

endmodule

bind ant_tour_roulette_select ats_check u_ats_check (.*);
